>>> hdl/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
// no dependencies

package ffha_pkg;

  localparam int DEF_MAX_EXTENTS  = 64;
  localparam int DEF_HEADER_BYTES = 4;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_NOFIT = 3'd2;
  localparam logic [2:0] ST_STACK = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  // request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // one free extent as stored in the table memory
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } extent_t;

endpackage

>>> hdl/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator
// holds the extent table memory and the request sequencer; uses ffha_pkg

// The free table is one synchronous memory of {start, length} extents kept in
// address order. A request walks the table entry by entry (a memory read, then
// a compare on the registered data). Removing an extent (exact fit or double
// merge) or inserting a new one shifts the tail of the table one moved entry at
// a time, a read and then a write for each. After reset the block writes the
// initial extent before it takes an item; a heap_base write is taken only while
// the block is idle and rebuilds the table in that same cycle.
module first_fit_heap_allocator #(
  parameter int MAX_EXTENTS  = ffha_pkg::DEF_MAX_EXTENTS,
  parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] heap_base,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] request_size,
  input  logic [31:0] stack_pointer,
  input  logic [31:0] block_address,
  input  logic [31:0] block_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] user_address,
  output logic [31:0] header_address,
  output logic [31:0] header_value,
  output logic [31:0] high_water
);
  import ffha_pkg::*;

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
  localparam logic [32:0] HDR = 33'(HEADER_BYTES);
  localparam logic [33:0] MASK32 = 34'h0_FFFF_FFFF;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_A_RD, S_A_EV, S_RM_RD, S_RM_WR,
    S_F_RD, S_F_EV, S_F_DEC, S_I_RD, S_I_WR, S_DONE
  } state_t;

  state_t state;

  // extent table memory
  extent_t mem [MAX_EXTENTS];
  extent_t rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  extent_t wdata;
  logic we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // request registers
  logic          req_act;
  logic [32:0]   need;
  logic [31:0]   sp;
  logic [31:0]   faddr;
  logic [31:0]   fbytes;
  logic [CW-1:0] idx;
  logic [CW-1:0] jdx;
  logic [CW-1:0] count;
  logic [31:0]   high_mark;
  extent_t       prev;
  extent_t       nxt;
  logic          have_next;

  // result staging
  logic [2:0]  r_status;
  logic [31:0] r_user, r_haddr, r_hval;

  // allocate compare on the entry just read
  logic        fits;
  logic [32:0] a_end;
  assign fits  = need <= {1'b0, rdata.length};
  assign a_end = {1'b0, rdata.start} + need;

  // free merge decision
  logic        mp, mn;
  logic [32:0] prev_end;
  logic [32:0] prev_sum;
  logic [31:0] ns;
  logic [32:0] nl0;
  logic [33:0] ns_end;
  logic [33:0] next_sum;
  logic [32:0] nl;

  always_comb begin
    prev_end = {1'b0, prev.start} + {1'b0, prev.length};
    prev_sum = {1'b0, prev.length} + {1'b0, fbytes};
    mp  = (idx != '0) && (prev_end == {1'b0, faddr}) && !prev_sum[32];
    ns  = mp ? prev.start : faddr;
    nl0 = mp ? prev_sum : {1'b0, fbytes};
    ns_end   = {2'b0, ns} + {1'b0, nl0};
    next_sum = {1'b0, nl0} + {2'b0, nxt.length};
    mn = have_next && (ns_end == {2'b0, nxt.start}) && (next_sum <= MASK32);
    nl = mn ? next_sum[32:0] : nl0;
  end

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = idx[AW-1:0];
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = '{start: 32'h0, length: 32'hFFFF_FFFF};
      end
      S_IDLE: begin
        if (cfg_valid) begin
          we    = 1'b1;
          wdata = '{start: heap_base, length: 32'hFFFF_FFFF - heap_base};
        end
      end
      S_A_EV: begin
        if (fits && !(a_end >= {1'b0, sp}) && !(need == {1'b0, rdata.length})) begin
          we    = 1'b1;
          waddr = idx[AW-1:0];
          wdata = '{start: a_end[31:0], length: rdata.length - need[31:0]};
        end
      end
      S_RM_RD: raddr = AW'(idx + 1'b1);
      S_RM_WR: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = rdata;
      end
      S_F_DEC: begin
        if (mp) begin
          we    = 1'b1;
          waddr = AW'(idx - 1'b1);
          wdata = '{start: prev.start, length: nl[31:0]};
        end else if (mn) begin
          we    = 1'b1;
          waddr = idx[AW-1:0];
          wdata = '{start: faddr, length: nl[31:0]};
        end
      end
      S_I_RD: begin
        raddr = AW'(jdx - 1'b1);
        if (jdx == idx) begin
          we    = 1'b1;
          waddr = idx[AW-1:0];
          wdata = '{start: faddr, length: fbytes};
        end
      end
      S_I_WR: begin
        we    = 1'b1;
        waddr = jdx[AW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CW'(1);
      high_mark <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (cfg_valid) begin
            count     <= CW'(1);
            high_mark <= heap_base;
          end else if (in_valid) begin
            req_act   <= action;
            need      <= {1'b0, request_size} + HDR;
            sp        <= stack_pointer;
            faddr     <= block_address - HDR[31:0];
            fbytes    <= block_bytes;
            idx       <= '0;
            have_next <= 1'b0;
            r_status  <= ST_OK;
            r_user    <= '0;
            r_haddr   <= '0;
            r_hval    <= '0;
            if (action == ACT_FREE) begin
              state <= S_F_RD;
            end else if (request_size == '0) begin
              r_status <= ST_ZERO;
              state    <= S_DONE;
            end else begin
              state <= S_A_RD;
            end
          end
        end
        S_A_RD: begin
          if (idx == count) begin
            r_status <= ST_NOFIT;
            state    <= S_DONE;
          end else begin
            state <= S_A_EV;
          end
        end
        S_A_EV: begin
          if (!fits) begin
            idx   <= idx + 1'b1;
            state <= S_A_RD;
          end else if (a_end >= {1'b0, sp}) begin
            r_status <= ST_STACK;
            state    <= S_DONE;
          end else begin
            r_user  <= rdata.start + HDR[31:0];
            r_haddr <= rdata.start;
            r_hval  <= need[31:0];
            if (a_end > {1'b0, high_mark}) high_mark <= a_end[31:0];
            state <= (need == {1'b0, rdata.length}) ? S_RM_RD : S_DONE;
          end
        end
        S_RM_RD: begin
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          idx   <= idx + 1'b1;
          state <= S_RM_RD;
        end
        S_F_RD: state <= (idx == count) ? S_F_DEC : S_F_EV;
        S_F_EV: begin
          if (rdata.start < faddr) begin
            prev  <= rdata;
            idx   <= idx + 1'b1;
            state <= S_F_RD;
          end else begin
            nxt       <= rdata;
            have_next <= 1'b1;
            state     <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          if (mp && mn) begin
            state <= S_RM_RD;
          end else if (mp || mn) begin
            state <= S_DONE;
          end else if (count >= CNT_MAX) begin
            r_status <= ST_FULL;
            state    <= S_DONE;
          end else begin
            jdx   <= count;
            state <= S_I_RD;
          end
        end
        S_I_RD: begin
          if (jdx == idx) begin
            count <= count + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_I_WR;
          end
        end
        S_I_WR: begin
          jdx   <= jdx - 1'b1;
          state <= S_I_RD;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            status         <= r_status;
            user_address   <= r_user;
            header_address <= r_haddr;
            header_value   <= r_hval;
            high_water     <= high_mark;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // table never holds more extents than it has room for
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("extent count exceeds table size");

  // a table-full result only comes from a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && r_status == ST_FULL) |-> count == CNT_MAX)
    else $error("table full reported with room left");

  // an accepted item leaves the idle state
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  // a free never yields allocation addresses
  a_free_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && req_act == ACT_FREE) |-> (r_user == '0 && r_hval == '0))
    else $error("free produced an allocation result");
`endif

endmodule

>>> tb/sv/tb_first_fit_heap_allocator.sv
// testbench of the first-fit heap allocator: directed table, then random
// traffic checked against a behavioral extent table; uses ffha_pkg
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int NEXT = DEF_MAX_EXTENTS;
  localparam int HB = DEF_HEADER_BYTES;
  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * NEXT + 40;

  typedef struct {
    logic act;
    logic [31:0] size;
    logic [31:0] sp;
    logic [31:0] addr;
    logic [31:0] bytes;
  } heap_req_t;

  typedef struct {
    logic [2:0] st;
    logic [31:0] ua;
    logic [31:0] ha;
    logic [31:0] hv;
    logic [31:0] hw;
  } heap_res_t;

  typedef struct {
    heap_req_t r;
    bit typed;
    heap_res_t e;
  } table_row_t;

  typedef struct {
    logic [31:0] ua;
    logic [31:0] bytes;
  } live_block_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [31:0] heap_base;
  logic in_valid, in_ready, action;
  logic [31:0] request_size, stack_pointer, block_address, block_bytes;
  logic out_valid, out_ready;
  logic [2:0] status;
  logic [31:0] user_address, header_address, header_value, high_water;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .heap_base(heap_base),
    .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .request_size(request_size), .stack_pointer(stack_pointer),
    .block_address(block_address), .block_bytes(block_bytes),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .user_address(user_address), .header_address(header_address),
    .header_value(header_value), .high_water(high_water)
  );

  always #6 clk = ~clk;

  // free extent table of the behavioral allocator
  logic [31:0] ext_start [NEXT];
  logic [31:0] ext_len [NEXT];
  int ext_cnt;
  logic [31:0] hmark;

  heap_res_t pending_q[$];
  live_block_t live_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int n_ok = 0, n_zero = 0, n_nofit = 0, n_stack = 0, n_full = 0, n_free = 0;
  bit tx_idle = 1'b1, rx_idle = 1'b1;
  int tx_gap = 0;
  int rx_hold = 0;

  function automatic void rebuild_heap(logic [31:0] base);
    ext_start[0] = base;
    ext_len[0] = 32'hFFFF_FFFF - base;
    ext_cnt = 1;
    hmark = base;
  endfunction

  function automatic void drop_extent(int k);
    for (int i = k; i + 1 < ext_cnt; i++) begin
      ext_start[i] = ext_start[i + 1];
      ext_len[i] = ext_len[i + 1];
    end
    ext_cnt--;
  endfunction

  // one request applied to the extent table
  function automatic heap_res_t heap_step(heap_req_t r);
    heap_res_t o;
    logic [63:0] need, blk_end, pe, sum, ns, nl;
    logic [31:0] base_addr;
    int i, p;
    bit mp, mn;
    o = '{ST_OK, 32'd0, 32'd0, 32'd0, 32'd0};
    if (r.act == ACT_ALLOC) begin
      if (r.size == 0) begin
        o.st = ST_ZERO;
      end else begin
        need = 64'(r.size) + HB;
        i = 0;
        while (i < ext_cnt && need > 64'(ext_len[i])) i++;
        if (i >= ext_cnt) begin
          o.st = ST_NOFIT;
        end else begin
          blk_end = 64'(ext_start[i]) + need;
          if (blk_end >= 64'(r.sp)) begin
            o.st = ST_STACK;
          end else begin
            o.ua = ext_start[i] + 32'(HB);
            o.ha = ext_start[i];
            o.hv = need[31:0];
            if (blk_end > 64'(hmark)) hmark = blk_end[31:0];
            if (64'(ext_len[i]) == need) begin
              drop_extent(i);
            end else begin
              ext_start[i] = blk_end[31:0];
              ext_len[i] = ext_len[i] - need[31:0];
            end
          end
        end
      end
    end else begin
      base_addr = r.addr - 32'(HB);
      p = 0;
      while (p < ext_cnt && ext_start[p] < base_addr) p++;
      ns = 64'(base_addr);
      nl = 64'(r.bytes);
      mp = 1'b0;
      mn = 1'b0;
      if (p > 0) begin
        pe = 64'(ext_start[p - 1]) + 64'(ext_len[p - 1]);
        sum = 64'(ext_len[p - 1]) + 64'(r.bytes);
        if (pe == 64'(base_addr) && sum <= MASK32) begin
          mp = 1'b1;
          ns = 64'(ext_start[p - 1]);
          nl = sum;
        end
      end
      if (p < ext_cnt) begin
        sum = nl + 64'(ext_len[p]);
        if (ns + nl == 64'(ext_start[p]) && sum <= MASK32) begin
          mn = 1'b1;
          nl = sum;
        end
      end
      if (mp && mn) begin
        ext_len[p - 1] = nl[31:0];
        drop_extent(p);
      end else if (mp) begin
        ext_len[p - 1] = nl[31:0];
      end else if (mn) begin
        ext_start[p] = base_addr;
        ext_len[p] = nl[31:0];
      end else if (ext_cnt >= NEXT) begin
        o.st = ST_FULL;
      end else begin
        for (i = ext_cnt; i > p; i--) begin
          ext_start[i] = ext_start[i - 1];
          ext_len[i] = ext_len[i - 1];
        end
        ext_start[p] = base_addr;
        ext_len[p] = nl[31:0];
        ext_cnt++;
      end
    end
    o.hw = hmark;
    return o;
  endfunction

  // cycle counter and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request, field checks
  initial begin : result_side
    int n;
    heap_res_t e;
    forever begin
      n = rx_idle ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: status %0d", status);
      end else begin
        e = pending_q.pop_front();
        if (status !== e.st || user_address !== e.ua || header_address !== e.ha ||
            header_value !== e.hv || high_water !== e.hw) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st %0d ua %h ha %h hv %h hw %h / got %0d %h %h %h %h",
                     e.st, e.ua, e.ha, e.hv, e.hw, status, user_address,
                     header_address, header_value, high_water);
        end
      end
    end
  end

  // offer one item, then predict its result once accepted
  task automatic send_req(heap_req_t r, bit typed, heap_res_t e);
    heap_res_t o;
    repeat (tx_gap) @(posedge clk);
    in_valid <= 1'b1;
    action <= r.act;
    request_size <= r.size;
    stack_pointer <= r.sp;
    block_address <= r.addr;
    block_bytes <= r.bytes;
    do @(posedge clk); while (!in_ready);
    sent++;
    o = heap_step(r);
    pending_q.push_back(typed ? e : o);
    case (o.st)
      ST_OK: if (r.act == ACT_ALLOC) n_ok++; else n_free++;
      ST_ZERO: n_zero++;
      ST_NOFIT: n_nofit++;
      ST_STACK: n_stack++;
      default: n_full++;
    endcase
    if (r.act == ACT_ALLOC && o.st == ST_OK) live_q.push_back('{o.ua, o.hv});
    tx_gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (tx_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic stop_input();
    if (tx_gap == 0) in_valid <= 1'b0;
    tx_gap = 1;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_heap_base(logic [31:0] v);
    stop_input();
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    heap_base <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rebuild_heap(v);
    live_q.delete();
  endtask

  // mostly alloc/free of live blocks, some broken or random requests
  function automatic heap_req_t random_req();
    heap_req_t r;
    int k, pick;
    live_block_t b;
    pick = $urandom_range(0, 99);
    r = '{ACT_ALLOC, $urandom_range(1, 256), 32'hFFFF_FFFF, $urandom, $urandom};
    if (pick < 5) r.size = 0;
    else if (pick < 9) r.size = $urandom;
    if ($urandom_range(0, 9) == 0) r.sp = hmark + $urandom_range(0, 512);
    if (pick >= 45 && pick < 85 && live_q.size() > 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      b = live_q[k];
      live_q.delete(k);
      r.act = ACT_FREE;
      r.addr = b.ua;
      r.bytes = b.bytes;
    end else if (pick >= 85) begin
      r = '{logic'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom};
    end
    return r;
  endfunction

  task automatic random_phase(int n);
    heap_res_t none;
    none = '{ST_OK, 32'd0, 32'd0, 32'd0, 32'd0};
    repeat (n) send_req(random_req(), 1'b0, none);
  endtask

  // directed requests on a heap based at zero
  table_row_t dir_rows[] = '{
    '{'{ACT_ALLOC, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1, '{ST_ZERO, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1,
      '{ST_NOFIT, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'd16, 32'd10, 32'd0, 32'd0}, 1, '{ST_STACK, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'd16, 32'd20, 32'd0, 32'd0}, 1, '{ST_STACK, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'd16, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1, '{ST_OK, 4, 0, 20, 20}},
    '{'{ACT_ALLOC, 32'd8, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1, '{ST_OK, 24, 20, 12, 32}},
    '{'{ACT_ALLOC, 32'd32, 32'hFFFF_FFFF, 32'd0, 32'd0}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'd4, 32'd20}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'd16, 32'hFFFF_FFFF, 32'd0, 32'd0}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'd4, 32'd20}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'd36, 32'd36}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'd24, 32'd12}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'd0, 32'd0}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'd2, 32'd8}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'h104, 32'hFFFF_FFF0}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'h84, 32'h80}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_FREE, 32'd0, 32'd0, 32'd0, 32'd0}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0, '{ST_OK, 0, 0, 0, 0}},
    '{'{ACT_ALLOC, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0}, 0, '{ST_OK, 0, 0, 0, 0}}
  };

  initial begin : stimulus
    heap_res_t none;
    heap_req_t r;
    none = '{ST_OK, 32'd0, 32'd0, 32'd0, 32'd0};
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    heap_base <= 32'd0;
    in_valid <= 1'b0;
    action <= ACT_ALLOC;
    request_size <= 32'd0;
    stack_pointer <= 32'd0;
    block_address <= 32'd0;
    block_bytes <= 32'd0;
    rebuild_heap(32'd0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_heap_base(32'd0);
    foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

    write_heap_base($urandom_range(0, 32'hFFFF));
    random_phase(300);

    // result side holds off while items keep coming back to back
    tx_idle = 1'b0;
    rx_hold = 400;
    random_phase(20);
    tx_idle = 1'b1;
    stop_input();
    wait_drained();

    // fragment the heap until the extent table overflows
    write_heap_base(32'h1000);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    r = '{ACT_ALLOC, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0};
    repeat (140) begin
      r.size = $urandom_range(1, 64);
      send_req(r, 1'b0, none);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    r.act = ACT_FREE;
    for (int i = 0; i < live_q.size(); i += 2) begin
      r.addr = live_q[i].ua;
      r.bytes = live_q[i].bytes;
      send_req(r, 1'b0, none);
    end

    write_heap_base(32'hFFFF_FFF0);
    random_phase(20);
    write_heap_base(32'hFFFF_FFFF);
    random_phase(10);
    write_heap_base($urandom);
    random_phase(300);

    stop_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d requests: %0d allocations, %0d frees, %0d zero, %0d no fit,",
             sent, n_ok, n_free, n_zero, n_nofit);
    $display("%0d stack collisions, %0d table full, over six heap bases",
             n_stack, n_full);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
